// File: sv/tsvm_pkg.sv
// ----------------------------------------------------------------------------
// Tagged stack machine package
// Shared types, opcodes, status codes and tag codes.
// ----------------------------------------------------------------------------
`default_nettype none
package tsvm_pkg;

  localparam int unsigned StackDepthDefault = 64;

  typedef enum logic [3:0] {
    OP_RET = 4'd0, OP_CONST = 4'd1, OP_NIL = 4'd2, OP_TRUE = 4'd3, OP_PUSH_FALSE = 4'd4,
    OP_NEG = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7, OP_MUL = 4'd8, OP_DIV = 4'd9,
    OP_NOT = 4'd10, OP_EQ = 4'd11, OP_LT = 4'd12, OP_LE = 4'd13,
    OP_NOP14 = 4'd14, OP_NOP15 = 4'd15
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CONT = 3'd0, ST_RET = 3'd1, ST_TYPE = 3'd2, ST_STACK = 3'd3, ST_DIV0 = 3'd4
  } status_e;

  localparam logic [1:0] TagNil  = 2'd0;
  localparam logic [1:0] TagBool = 2'd1;
  localparam logic [1:0] TagNum  = 2'd2;

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [1:0]  tag;
    logic [63:0] value;
    logic [1:0]  need;
    logic        is_push;
  } instr_t;

  function automatic logic [63:0] sat_signed(input logic [63:0] mag, input logic ovf,
                                             input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = (ovf || mag > SignBit) ? SignBit : (64'd0 - mag);
    end else begin
      r = (ovf || mag > MaxPos) ? MaxPos : mag;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/tsvm_if.sv
// ----------------------------------------------------------------------------
// Tagged stack machine channels
// Instruction input channel and result output channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface tsvm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [1:0]  const_tag;
  logic signed [63:0] const_value;
  modport source (output valid, opcode, const_tag, const_value, input ready);
  modport sink (input valid, opcode, const_tag, const_value, output ready);
endinterface

interface tsvm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  top_tag;
  logic signed [63:0] top_value;
  logic [6:0]  stack_depth;
  modport source (output valid, status, top_tag, top_value, stack_depth, input ready);
  modport sink (input valid, status, top_tag, top_value, stack_depth, output ready);
endinterface
`default_nettype wire

// File: sv/tagged_stack_vm_executor.sv
// ----------------------------------------------------------------------------
// Tagged stack machine executor
// Runs one stack instruction per item on a stack of nil, boolean and number values.
// ----------------------------------------------------------------------------
// Each item yields one result item. On the way to its result, most instructions
// pass the queue register, the operand read and the execute register of the back
// end, and the back end takes a new item only while idle or as the last result is taken.
// Multiply adds four 16-bit digit steps and a hand-off, and divide adds one
// quotient bit a cycle over 96 bits and a hand-off.
// A two-entry queue holds instructions while the back end works.
`default_nettype none
module tagged_stack_vm_executor #(
  parameter int unsigned STACK_DEPTH = tsvm_pkg::StackDepthDefault
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  tsvm_in_if.sink    in_if,
  tsvm_out_if.source out_if
);

  tsvm_pkg::instr_t instr;
  logic ivalid, iready;

  tsvm_front u_front (
    .clk_i, .rst_ni, .in_if, .instr_o(instr), .valid_o(ivalid), .ready_i(iready)
  );

  tsvm_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk_i, .rst_ni, .instr_i(instr), .valid_i(ivalid), .ready_o(iready), .out_if
  );

endmodule
`default_nettype wire

// File: sv/tsvm_front.sv
// ----------------------------------------------------------------------------
// Tagged stack machine front end
// Accepts instructions, normalizes constants and queues decoded items.
// ----------------------------------------------------------------------------
`default_nettype none
module tsvm_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  tsvm_in_if.sink             in_if,
  output tsvm_pkg::instr_t    instr_o,
  output logic                valid_o,
  input  wire logic           ready_i
);

  tsvm_pkg::instr_t q0_q, q1_q, dec;
  logic [1:0] cnt_q, cnt_d;
  logic push_w, pop_w;

  always_comb begin
    dec.opcode  = in_if.opcode;
    dec.tag     = tsvm_pkg::TagNil;
    dec.value   = 64'd0;
    dec.need    = 2'd0;
    dec.is_push = 1'b0;
    case (tsvm_pkg::opcode_e'(in_if.opcode))
      tsvm_pkg::OP_CONST: begin
        dec.is_push = 1'b1;
        if (in_if.const_tag == tsvm_pkg::TagBool) begin
          dec.tag   = tsvm_pkg::TagBool;
          dec.value = {63'd0, in_if.const_value != 64'd0};
        end else if (in_if.const_tag == tsvm_pkg::TagNum) begin
          dec.tag   = tsvm_pkg::TagNum;
          dec.value = in_if.const_value;
        end
      end
      tsvm_pkg::OP_NIL: dec.is_push = 1'b1;
      tsvm_pkg::OP_TRUE: begin
        dec.is_push = 1'b1;
        dec.tag     = tsvm_pkg::TagBool;
        dec.value   = 64'd1;
      end
      tsvm_pkg::OP_PUSH_FALSE: begin
        dec.is_push = 1'b1;
        dec.tag     = tsvm_pkg::TagBool;
      end
      tsvm_pkg::OP_RET, tsvm_pkg::OP_NEG, tsvm_pkg::OP_NOT: dec.need = 2'd1;
      tsvm_pkg::OP_ADD, tsvm_pkg::OP_SUB, tsvm_pkg::OP_MUL, tsvm_pkg::OP_DIV,
      tsvm_pkg::OP_EQ, tsvm_pkg::OP_LT, tsvm_pkg::OP_LE: dec.need = 2'd2;
      default: dec.need = 2'd0;
    endcase
  end

  assign in_if.ready = (cnt_q != 2'd2);
  assign push_w  = in_if.valid && in_if.ready;
  assign pop_w   = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign instr_o = q0_q;
  assign cnt_d   = cnt_q + {1'b0, push_w} - {1'b0, pop_w};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_w) begin
      q0_q <= (cnt_q == 2'd2) ? q1_q : dec;
    end else if (push_w && cnt_q == 2'd0) begin
      q0_q <= dec;
    end
    if (push_w && (cnt_q - {1'b0, pop_w}) == 2'd1) begin
      q1_q <= dec;
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop_w) |=> cnt_q == 2'd2) else $error("queue lost an item");
  a_push_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_w && cnt_q == 2'd0) |=> valid_o) else $error("queued item not shown");

endmodule
`default_nettype wire

// File: sv/tsvm_muldiv.sv
// ----------------------------------------------------------------------------
// Tagged stack machine multiply and divide unit
// Iterative Q32.32 multiply (16-bit digits) and restoring divide (one bit a cycle).
// ----------------------------------------------------------------------------
`default_nettype none
module tsvm_muldiv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        is_div_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;
  state_e state_q;
  logic [63:0] x_q, y_q, rem_q, q_q, res_q;
  logic [127:0] acc_q;
  logic [6:0] cnt_q;
  logic neg_q, ovf_q;
  logic [64:0] rem_sh;
  logic [15:0] ydig;
  logic [79:0] pp;
  logic [127:0] mul_sum;
  logic [63:0] mag;

  assign rem_sh  = {rem_q, (cnt_q >= 7'd32) ? x_q[63] : 1'b0};
  assign ydig    = y_q[15:0];
  assign pp      = {16'd0, x_q} * {64'd0, ydig};
  assign mul_sum = acc_q + ({48'd0, pp} << {cnt_q[1:0], 4'd0});
  assign done_o  = (state_q == S_DONE);
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            neg_q <= a_i[63] ^ b_i[63];
            x_q   <= a_i[63] ? 64'd0 - a_i : a_i;
            y_q   <= b_i[63] ? 64'd0 - b_i : b_i;
            acc_q <= 128'd0;
            rem_q <= 64'd0;
            q_q   <= 64'd0;
            ovf_q <= 1'b0;
            cnt_q <= is_div_i ? 7'd95 : 7'd0;
            state_q <= is_div_i ? S_DIV : S_MUL;
          end
        end
        S_MUL: begin
          acc_q <= mul_sum;
          y_q   <= y_q >> 16;
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q[1:0] == 2'd3) begin
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (cnt_q >= 7'd32) begin
            x_q <= {x_q[62:0], 1'b0};
          end
          if (rem_sh >= {1'b0, y_q}) begin
            rem_q <= 64'(rem_sh - {1'b0, y_q});
            if (cnt_q >= 7'd64) begin
              ovf_q <= 1'b1;
            end else begin
              q_q <= q_q | (64'd1 << cnt_q[5:0]);
            end
          end else begin
            rem_q <= rem_sh[63:0];
          end
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign mag = (state_q == S_MUL) ? acc_q[95:32] : q_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL && cnt_q[1:0] == 2'd3) begin
      res_q <= tsvm_pkg::sat_signed(mul_sum[95:32], mul_sum[127:96] != 32'd0, neg_q);
    end else if (state_q == S_DIV && cnt_q == 7'd0) begin
      res_q <= tsvm_pkg::sat_signed(
        (rem_sh >= {1'b0, y_q}) ? (q_q | 64'd1) : mag, ovf_q, neg_q);
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_IDLE) else $error("unit did not return to idle");
  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE) else $error("start while busy");
  a_mul_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> cnt_q <= 7'd3) else $error("multiply ran too long");

endmodule
`default_nettype wire

// File: sv/tsvm_back.sv
// ----------------------------------------------------------------------------
// Tagged stack machine back end
// Executes queued instructions on the tagged stack and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none
module tsvm_back #(
  parameter int unsigned STACK_DEPTH = tsvm_pkg::StackDepthDefault,
  localparam int unsigned PW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  tsvm_pkg::instr_t instr_i,
  input  wire logic        valid_i,
  output logic             ready_o,
  tsvm_out_if.source       out_if
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} state_e;
  state_e state_q;

  logic [1:0]  tags_mem [STACK_DEPTH];
  logic [63:0] vals_mem [STACK_DEPTH];
  logic [PW-1:0] sp_q, sp_d;
  logic [1:0]  ta_q, tb_q;
  logic [63:0] va_q, vb_q;
  tsvm_pkg::instr_t ins_q;
  logic [2:0]  st_q;
  logic [1:0]  otag_q, otag_d;
  logic [63:0] oval_q, oval_d;
  logic [PW-1:0] odep_q, odep_d;

  logic md_start, md_done;
  logic [63:0] md_res;
  logic [63:0] addr, sub;
  logic add_ovf, sub_ovf, lt;
  logic [AW-1:0] ia, ib;

  tsvm_pkg::status_e ex_st;
  logic [1:0]    ex_tag;
  logic [63:0]   ex_val;
  logic          ex_wr, ex_wait;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [1:0]    mem_wt;
  logic [63:0]   mem_wv;

  assign ia = AW'(sp_q - PW'(1));
  assign ib = AW'(sp_q - PW'(2));
  assign addr = va_q + vb_q;
  assign sub  = va_q - vb_q;
  assign add_ovf = !(va_q[63] ^ vb_q[63]) && (addr[63] ^ va_q[63]);
  assign sub_ovf = (va_q[63] ^ vb_q[63]) && (sub[63] ^ va_q[63]);
  assign lt = (va_q ^ tsvm_pkg::SignBit) < (vb_q ^ tsvm_pkg::SignBit);

  tsvm_muldiv u_md (
    .clk_i, .rst_ni, .start_i(md_start),
    .is_div_i(ins_q.opcode == tsvm_pkg::OP_DIV),
    .a_i(va_q), .b_i(vb_q), .done_o(md_done), .res_o(md_res)
  );

  assign ready_o = (state_q == S_IDLE) || (state_q == S_OUT && out_if.ready);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.status = st_q;
  assign out_if.top_tag = otag_q;
  assign out_if.top_value = oval_q;
  assign out_if.stack_depth = 7'(odep_q);

  assign md_start = (state_q == S_EXEC) && ex_wait;

  always_comb begin
    ex_st   = tsvm_pkg::ST_CONT;
    ex_tag  = tsvm_pkg::TagNum;
    ex_val  = 64'd0;
    ex_wr   = 1'b0;
    ex_wait = 1'b0;
    if (ins_q.is_push && sp_q >= PW'(STACK_DEPTH)) begin
      ex_st = tsvm_pkg::ST_STACK;
    end else if (sp_q < PW'(ins_q.need)) begin
      ex_st = tsvm_pkg::ST_STACK;
    end else begin
      case (tsvm_pkg::opcode_e'(ins_q.opcode))
        tsvm_pkg::OP_RET: ex_st = tsvm_pkg::ST_RET;
        tsvm_pkg::OP_CONST, tsvm_pkg::OP_NIL, tsvm_pkg::OP_TRUE,
        tsvm_pkg::OP_PUSH_FALSE: begin
          ex_tag = ins_q.tag; ex_val = ins_q.value; ex_wr = 1'b1;
        end
        tsvm_pkg::OP_NEG: begin
          if (tb_q != tsvm_pkg::TagNum) begin
            ex_st = tsvm_pkg::ST_TYPE;
          end else begin
            ex_val = (vb_q == tsvm_pkg::SignBit) ? tsvm_pkg::MaxPos : 64'd0 - vb_q;
            ex_wr  = 1'b1;
          end
        end
        tsvm_pkg::OP_NOT: begin
          ex_tag = tsvm_pkg::TagBool; ex_wr = 1'b1;
          ex_val = {63'd0, tb_q == tsvm_pkg::TagNil ||
                           (tb_q == tsvm_pkg::TagBool && vb_q == 64'd0)};
        end
        tsvm_pkg::OP_EQ: begin
          ex_tag = tsvm_pkg::TagBool; ex_wr = 1'b1;
          ex_val = {63'd0, ta_q == tb_q && va_q == vb_q};
        end
        tsvm_pkg::OP_NOP14, tsvm_pkg::OP_NOP15: ex_wr = 1'b0;
        default: begin
          if (ta_q != tsvm_pkg::TagNum || tb_q != tsvm_pkg::TagNum) begin
            ex_st = tsvm_pkg::ST_TYPE;
          end else begin
            case (tsvm_pkg::opcode_e'(ins_q.opcode))
              tsvm_pkg::OP_ADD: begin
                ex_wr  = 1'b1;
                ex_val = add_ovf ?
                  (va_q[63] ? tsvm_pkg::SignBit : tsvm_pkg::MaxPos) : addr;
              end
              tsvm_pkg::OP_SUB: begin
                ex_wr  = 1'b1;
                ex_val = sub_ovf ?
                  (va_q[63] ? tsvm_pkg::SignBit : tsvm_pkg::MaxPos) : sub;
              end
              tsvm_pkg::OP_LT: begin
                ex_wr = 1'b1; ex_tag = tsvm_pkg::TagBool; ex_val = {63'd0, lt};
              end
              tsvm_pkg::OP_LE: begin
                ex_wr = 1'b1; ex_tag = tsvm_pkg::TagBool;
                ex_val = {63'd0, lt || va_q == vb_q};
              end
              tsvm_pkg::OP_DIV: begin
                if (vb_q == 64'd0) ex_st = tsvm_pkg::ST_DIV0;
                else ex_wait = 1'b1;
              end
              default: ex_wait = 1'b1;
            endcase
          end
        end
      endcase
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ia;
    mem_wt = ex_tag;
    mem_wv = ex_val;
    sp_d   = sp_q;
    otag_d = otag_q;
    oval_d = oval_q;
    odep_d = odep_q;
    if (state_q == S_EXEC) begin
      if (ex_wr) begin
        mem_we = 1'b1;
        if (ins_q.is_push) begin
          mem_wa = AW'(sp_q);
          sp_d   = sp_q + PW'(1);
        end else if (ins_q.need == 2'd2) begin
          mem_wa = ib;
          sp_d   = sp_q - PW'(1);
        end
        otag_d = ex_tag;
        oval_d = ex_val;
        odep_d = sp_d;
      end else if (ex_st == tsvm_pkg::ST_RET) begin
        sp_d   = '0;
        otag_d = tb_q;
        oval_d = vb_q;
        odep_d = '0;
      end else if (ex_st != tsvm_pkg::ST_CONT) begin
        sp_d   = '0;
        otag_d = tsvm_pkg::TagNil;
        oval_d = 64'd0;
        odep_d = '0;
      end else if (!ex_wait) begin
        otag_d = (sp_q == '0) ? tsvm_pkg::TagNil : tb_q;
        oval_d = (sp_q == '0) ? 64'd0 : vb_q;
        odep_d = sp_q;
      end
    end else if (state_q == S_WAIT && md_done) begin
      mem_we = 1'b1;
      mem_wa = ib;
      mem_wt = tsvm_pkg::TagNum;
      mem_wv = md_res;
      sp_d   = sp_q - PW'(1);
      otag_d = tsvm_pkg::TagNum;
      oval_d = md_res;
      odep_d = sp_d;
    end
  end

  // Operands are read in the accept cycle; b is the top, a the one below.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ins_q <= instr_i;
      tb_q  <= tags_mem[ia];
      vb_q  <= vals_mem[ia];
      ta_q  <= tags_mem[ib];
      va_q  <= vals_mem[ib];
    end
    if (mem_we) begin
      tags_mem[mem_wa] <= mem_wt;
      vals_mem[mem_wa] <= mem_wv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      st_q    <= tsvm_pkg::ST_CONT;
      otag_q  <= tsvm_pkg::TagNil;
      oval_q  <= 64'd0;
      odep_q  <= '0;
    end else begin
      sp_q   <= sp_d;
      otag_q <= otag_d;
      oval_q <= oval_d;
      odep_q <= odep_d;
      case (state_q)
        S_IDLE, S_OUT: begin
          if (valid_i && ready_o) begin
            state_q <= S_EXEC;
          end else if (state_q == S_OUT && out_if.ready) begin
            state_q <= S_IDLE;
          end
        end
        S_EXEC: begin
          st_q    <= ex_st;
          state_q <= ex_wait ? S_WAIT : S_OUT;
        end
        S_WAIT: begin
          if (md_done) begin
            state_q <= S_OUT;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= PW'(STACK_DEPTH)) else $error("stack pointer past depth");
  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status >= tsvm_pkg::ST_TYPE) |-> out_if.stack_depth == 7'd0)
    else $error("error left values on stack");
  a_ret_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status == tsvm_pkg::ST_RET) |-> sp_q == '0)
    else $error("return left values on stack");

endmodule
`default_nettype wire
